@@ src/fpq_pkg.sv @@
package fpq_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_PURGE   = 2'd1,
    KIND_PROMOTE = 2'd2,
    KIND_POP     = 2'd3
  } kind_e;

  localparam int unsigned SenderW  = 16;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned CountW   = 7;

  // One stored entry
  typedef struct packed {
    logic [SenderW-1:0]  snd;
    logic [PayloadW-1:0] pay;
  } slot_t;

endpackage

@@ src/fpq_store.sv @@
module fpq_store #(
  parameter int unsigned AddrW = 9
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  fpq_pkg::slot_t     wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output fpq_pkg::slot_t     rdata_o
);
  import fpq_pkg::*;

  slot_t mem [2**AddrW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/five_level_priority_queue_purge.sv @@
// Channel  | valid     | stall     | payload
// request  | req_valid | req_stall | kind, sender, level, payload, count
// result   | res_valid | res_stall | out_sender, out_level, out_payload, last
//
// A push is taken while idle and the block stays ready for the next request.
// Purge walks every held entry of each level, promote every entry of each
// level but level 0: ST_SCAN loads the pointers of a level, ST_RD reads each
// entry and ST_MOD keeps it, moves it up a level or drops it.
// Pop reads the head of the first non-empty level in ST_POPRD and loads it into
// the result register in ST_POPW; a stalled result holds the walk. Reset clears
// state, result valid, pointers and counts only; the entry memory has no reset.
module five_level_priority_queue_purge #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned MAX_BURST   = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [fpq_pkg::SenderW-1:0]  sender_i,
  input  logic [fpq_pkg::LevelW-1:0]   level_i,
  input  logic [fpq_pkg::PayloadW-1:0] payload_i,
  input  logic [fpq_pkg::CountW-1:0]   count_i,
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output logic [fpq_pkg::SenderW-1:0]  out_sender_o,
  output logic [fpq_pkg::LevelW-1:0]   out_level_o,
  output logic [fpq_pkg::PayloadW-1:0] out_payload_o,
  output logic                         last_o
);
  import fpq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LvW  = $clog2(LEVELS);
  localparam int unsigned AddrW = LvW + PtrW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_POPRD = 6'b010000,
    ST_POPW  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [PtrW-1:0] head_q [LEVELS];
  logic [PtrW-1:0] tail_q [LEVELS];
  logic [CntW-1:0] fill_q [LEVELS];

  logic [1:0]          kind_q;
  logic [SenderW-1:0]  snd_q;
  logic [CountW-1:0]   left_q;
  logic [LvW-1:0]      lv_q;
  logic [PtrW-1:0]     rd_q, wr_q;
  logic [CntW-1:0]     n_q, kept_q;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  slot_t               wdata, rdata;

  logic                res_valid_q, last_q;
  logic [SenderW-1:0]  o_snd_q;
  logic [LevelW-1:0]   o_lv_q;
  logic [PayloadW-1:0] o_pay_q;

  fpq_store #(.AddrW(AddrW)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    nxt = (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + PtrW'(1);
  endfunction

  // True when no level other than lv holds entries
  function automatic logic ne_only(input logic [LvW-1:0] lv);
    ne_only = 1'b1;
    for (int l = 0; l < LEVELS; l++) begin
      if (LvW'(l) != lv && fill_q[l] != '0) ne_only = 1'b0;
    end
  endfunction

  // First non-empty level and whether any
  logic [LvW-1:0] ne_lv;
  logic           any_ne;
  always_comb begin
    ne_lv  = '0;
    any_ne = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        ne_lv  = LvW'(l);
        any_ne = 1'b1;
      end
    end
  end

  logic [LvW-1:0] up_lv;
  logic           up_ok;
  logic           match;
  assign up_lv = lv_q - LvW'(1);
  assign up_ok = (kind_q == KIND_PROMOTE) && (32'(fill_q[up_lv]) < QUEUE_DEPTH);
  assign match = rdata.snd == snd_q;

  logic push_ok;
  assign push_ok = (32'(level_i) < LEVELS) &&
                   (32'(fill_q[level_i[LvW-1:0]]) < QUEUE_DEPTH);

  logic req_acc;
  assign req_stall_o = (state_q != ST_IDLE);
  assign req_acc     = req_valid_i && !req_stall_o;

  // Result register loads when it is empty or being taken
  logic pop_load;
  assign pop_load = (state_q == ST_POPW) && (!res_valid_q || !res_stall_i);

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = {lv_q, wr_q};
    wdata = rdata;
    raddr = {lv_q, rd_q};
    if (state_q == ST_IDLE) begin
      we    = req_acc && (kind_i == KIND_PUSH) && push_ok;
      waddr = {level_i[LvW-1:0], tail_q[level_i[LvW-1:0]]};
      wdata = '{snd: sender_i, pay: payload_i};
    end else if (state_q == ST_MOD) begin
      if (match) begin
        we    = up_ok;
        waddr = {up_lv, tail_q[up_lv]};
      end else begin
        we    = 1'b1;
      end
    end else if (state_q == ST_POPRD) begin
      raddr = {ne_lv, head_q[ne_lv]};
    end else if (state_q == ST_POPW) begin
      // keep the head entry on the read port while the result waits
      raddr = {lv_q, head_q[lv_q]};
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop_load) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            kind_q <= kind_i;
            snd_q  <= sender_i;
            case (kind_i)
              KIND_PUSH: begin
                if (push_ok) begin
                  tail_q[level_i[LvW-1:0]] <= nxt(tail_q[level_i[LvW-1:0]]);
                  fill_q[level_i[LvW-1:0]] <= fill_q[level_i[LvW-1:0]] + CntW'(1);
                end
              end
              KIND_PURGE: begin
                lv_q    <= '0;
                state_q <= ST_SCAN;
              end
              KIND_PROMOTE: begin
                lv_q    <= LvW'(1);
                state_q <= ST_SCAN;
              end
              default: begin
                left_q  <= (32'(count_i) > MAX_BURST) ? CountW'(MAX_BURST) : count_i;
                state_q <= ST_POPRD;
              end
            endcase
          end
        end
        // Start walking one level
        ST_SCAN: begin
          rd_q    <= head_q[lv_q];
          wr_q    <= head_q[lv_q];
          n_q     <= fill_q[lv_q];
          kept_q  <= '0;
          state_q <= ST_RD;
        end
        ST_RD: begin
          if (n_q == '0) begin
            fill_q[lv_q] <= kept_q;
            tail_q[lv_q] <= wr_q;
            if (32'(lv_q) == LEVELS - 1) begin
              state_q <= ST_IDLE;
            end else begin
              lv_q    <= lv_q + LvW'(1);
              state_q <= ST_SCAN;
            end
          end else begin
            rd_q    <= nxt(rd_q);
            n_q     <= n_q - CntW'(1);
            state_q <= ST_MOD;
          end
        end
        // Keep, move up or drop the entry just read
        ST_MOD: begin
          if (match) begin
            if (up_ok) begin
              tail_q[up_lv] <= nxt(tail_q[up_lv]);
              fill_q[up_lv] <= fill_q[up_lv] + CntW'(1);
            end
          end else begin
            wr_q   <= nxt(wr_q);
            kept_q <= kept_q + CntW'(1);
          end
          state_q <= ST_RD;
        end
        // Choose level and issue read of its head
        ST_POPRD: begin
          if (left_q == '0 || !any_ne) begin
            state_q <= ST_IDLE;
          end else begin
            lv_q    <= ne_lv;
            state_q <= ST_POPW;
          end
        end
        ST_POPW: begin
          if (pop_load) begin
            o_snd_q      <= rdata.snd;
            o_pay_q      <= rdata.pay;
            o_lv_q       <= LevelW'(lv_q);
            head_q[lv_q] <= nxt(head_q[lv_q]);
            fill_q[lv_q] <= fill_q[lv_q] - CntW'(1);
            left_q       <= left_q - CountW'(1);
            // last when the count runs out or nothing else is held
            last_q <= (left_q == CountW'(1)) ||
                      (fill_q[lv_q] == CntW'(1) && ne_only(lv_q));
            state_q <= ST_POPRD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_sender_o  = o_snd_q;
  assign out_level_o   = o_lv_q;
  assign out_payload_o = o_pay_q;
  assign last_o        = last_q;

endmodule

@@ src/fpq_checker.sv @@
module fpq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_stall_o,
  input logic res_valid_o,
  input logic res_stall_i,
  input logic last_o
);

  // Results appear only while a request is in flight
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !$past(res_valid_o)) |-> $past(req_stall_o))
    else $error("result outside a request");

  // A stalled result stays valid and keeps its last flag
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_stall_i) |=> (res_valid_o && $stable(last_o)))
    else $error("stalled result changed");

  // A stalled request stays offered
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_stall_o) |=> req_valid_i)
    else $error("stalled request withdrawn");

endmodule

bind five_level_priority_queue_purge fpq_checker u_fpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o),
  .res_valid_o(res_valid_o),
  .res_stall_i(res_stall_i),
  .last_o     (last_o)
);

@@ verif/five_level_priority_queue_purge_test.sv @@
`timescale 1ns / 1ps

module five_level_priority_queue_purge_test;
  import fpq_pkg::*;

  localparam int unsigned Depth     = 64;
  localparam int unsigned NumLevels = 5;
  localparam int unsigned MaxBurst  = 64;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    kind_e               kind;
    logic [SenderW-1:0]  sender;
    logic [LevelW-1:0]   level;
    logic [PayloadW-1:0] payload;
    logic [CountW-1:0]   count;
  } request_t;

  typedef struct packed {
    logic [SenderW-1:0]  sender;
    logic [LevelW-1:0]   level;
    logic [PayloadW-1:0] payload;
    logic                last;
  } popped_t;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  logic [1:0] kind_i;
  logic [SenderW-1:0] sender_i;
  logic [LevelW-1:0] level_i;
  logic [PayloadW-1:0] payload_i;
  logic [CountW-1:0] count_i;
  logic res_valid_o;
  logic res_stall_i;
  logic [SenderW-1:0] out_sender_o;
  logic [LevelW-1:0] out_level_o;
  logic [PayloadW-1:0] out_payload_o;
  logic last_o;

  five_level_priority_queue_purge uut (.*);

  // Shadow of the queue contents, one SV queue per level
  slot_t   level_q [NumLevels][$];
  request_t pending_q [$];
  popped_t  popped_q [$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cycles;
  bit          hold_req;
  bit          pause_req;
  bit          stim_done;
  bit          req_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input popped_t got, input popped_t exp);
    errors++;
    $display("MISMATCH %s: got %h exp %h", what, got, exp);
  endtask

  // Apply one request to the shadow queues
  task automatic model_request(input request_t r);
    slot_t e;
    slot_t kept [$];
    popped_t p;
    int unsigned n;
    int unsigned lim;
    case (r.kind)
      KIND_PUSH: begin
        if (r.level < NumLevels && level_q[r.level].size() < Depth)
          level_q[r.level].push_back({r.sender, r.payload});
      end
      KIND_PURGE, KIND_PROMOTE: begin
        for (int l = (r.kind == KIND_PURGE) ? 0 : 1; l < NumLevels; l++) begin
          kept.delete();
          foreach (level_q[l][i]) begin
            e = level_q[l][i];
            if (e.snd != r.sender) kept.push_back(e);
            else if (r.kind == KIND_PROMOTE && level_q[l-1].size() < Depth)
              level_q[l-1].push_back(e);
          end
          level_q[l] = kept;
        end
      end
      default: begin
        lim = (r.count > MaxBurst) ? MaxBurst : r.count;
        n = 0;
        for (int l = 0; l < NumLevels; l++) begin
          while (level_q[l].size() > 0 && n < lim) begin
            e = level_q[l].pop_front();
            p = '{sender: e.snd, level: l[LevelW-1:0], payload: e.pay, last: 1'b0};
            popped_q.push_back(p);
            n++;
          end
        end
        if (n > 0) popped_q[popped_q.size()-1].last = 1'b1;
      end
    endcase
  endtask

  function automatic request_t rand_request(input bit noisy);
    request_t r;
    int unsigned pick;
    r.sender  = noisy ? 16'($urandom) : 16'($urandom_range(0, 7));
    r.payload = $urandom;
    r.level   = noisy ? 3'($urandom) : 3'($urandom_range(0, NumLevels-1));
    r.count   = noisy ? 7'($urandom) : 7'($urandom_range(0, 20));
    pick = $urandom_range(0, 99);
    if (pick < 60) r.kind = KIND_PUSH;
    else if (pick < 70) r.kind = KIND_PURGE;
    else if (pick < 82) r.kind = KIND_PROMOTE;
    else r.kind = KIND_POP;
    return r;
  endfunction

  function automatic request_t mk(input kind_e k, input int s, input int l,
                                  input logic [31:0] p, input int c);
    request_t r;
    r.kind = k; r.sender = s[15:0]; r.level = l[2:0]; r.payload = p; r.count = c[6:0];
    return r;
  endfunction

  // Request acceptance as seen at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_taken <= 1'b0;
    else req_taken <= req_valid_i && !req_stall_o;
  end

  // Driver: presents pending requests with random gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      send_gap    <= 0;
    end else if (req_taken) begin
      void'(pending_q.pop_front());
      send_gap <= $urandom_range(0, 15) * $urandom_range(0, 1);
      if (pending_q.size() > 0 && !pause_req && $urandom_range(0, 1)) begin
        {kind_i, sender_i, level_i, payload_i, count_i} <= pending_q[0];
        req_valid_i <= 1'b1;
      end else begin
        req_valid_i <= 1'b0;
      end
    end else if (!req_valid_i) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_q.size() > 0 && !pause_req) begin
        {kind_i, sender_i, level_i, payload_i, count_i} <= pending_q[0];
        req_valid_i <= 1'b1;
      end
    end
  end

  // Monitor: model accepted requests, check accepted results
  always @(posedge clk_i) begin
    popped_t got;
    popped_t exp;
    bit      busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (req_valid_i && !req_stall_o) begin
        model_request({kind_e'(kind_i), sender_i, level_i, payload_i, count_i});
        busy = 1'b1;
      end
      if (res_valid_o && !res_stall_i) begin
        busy = 1'b1;
        got = '{out_sender_o, out_level_o, out_payload_o, last_o};
        if (popped_q.size() == 0) report("unexpected", got, got);
        else begin
          exp = popped_q.pop_front();
          if (got.sender !== exp.sender) report("sender", got, exp);
          if (got.level !== exp.level) report("level", got, exp);
          if (got.payload !== exp.payload) report("payload", got, exp);
          if (got.last !== exp.last) report("last", got, exp);
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("five_level_priority_queue_purge verification failed");
        $finish;
      end
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
      recv_gap    <= 0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles < 600) begin
      res_stall_i <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else if (recv_gap > 0) begin
      res_stall_i <= 1'b1;
      recv_gap    <= recv_gap - 1;
    end else begin
      res_stall_i <= 1'b0;
      if (res_valid_o && $urandom_range(0, 3) == 0) recv_gap <= $urandom_range(0, 15);
      if (!hold_req) hold_cycles <= 0;
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; hold_req = 0; pause_req = 0; stim_done = 0;
    kind_i = '0; sender_i = '0; level_i = '0; payload_i = '0; count_i = '0;
    req_valid_i = 1'b0;
    res_stall_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every kind, full level, bad level, capped pop
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 5));
    pending_q.push_back(mk(KIND_PUSH, 16'hffff, 0, 32'hffffffff, 0));
    pending_q.push_back(mk(KIND_PUSH, 0, 4, 0, 0));
    pending_q.push_back(mk(KIND_PUSH, 1, 7, 32'h1234, 0));
    pending_q.push_back(mk(KIND_PUSH, 1, 5, 32'h5678, 0));
    pending_q.push_back(mk(KIND_PUSH, 2, 2, 32'haaaa5555, 0));
    pending_q.push_back(mk(KIND_PUSH, 1, 1, 32'h1, 0));
    pending_q.push_back(mk(KIND_PROMOTE, 1, 0, 0, 0));
    pending_q.push_back(mk(KIND_PURGE, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 127));
    for (int i = 0; i < 66; i++) pending_q.push_back(mk(KIND_PUSH, i % 3, 1, i, 0));
    pending_q.push_back(mk(KIND_PROMOTE, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 64));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 65));
    // Long receiver hold while the sender keeps offering
    hold_req = 1;
    for (int i = 0; i < 40; i++) pending_q.push_back(rand_request(0));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 64));
    wait (pending_q.size() == 0);
    wait (hold_cycles >= 600);
    hold_req = 0;
    // Sender pauses until all results drain
    pause_req = 1;
    wait (popped_q.size() == 0);
    pause_req = 0;

    for (int i = 0; i < 150; i++) pending_q.push_back(rand_request(i % 8 == 0));
    pending_q.push_back(mk(KIND_POP, 0, 0, 0, 64));
    wait (pending_q.size() == 0);
    wait (popped_q.size() == 0);
    repeat (800) @(posedge clk_i);

    if (errors == 0) $display("five_level_priority_queue_purge verification clean");
    else $display("five_level_priority_queue_purge verification failed");
    $finish;
  end

endmodule
